[rtl/bdq_pkg.sv]
// Shared types, action and status codes, and controller/datapath bundles
// for the bounded deque. No dependencies.

package bdq_pkg;

    typedef logic        [2:0]  action_t;
    typedef logic signed [31:0] word_t;
    typedef logic        [1:0]  status_t;

    // Action codes; the unused codes behave as a query
    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_BACK  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_BACK   = 3'd3;
    localparam action_t ACT_REMOVE     = 3'd4;
    localparam action_t ACT_QUERY      = 3'd5;

    // Result status codes
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_EMPTY   = 2'd2;
    localparam status_t ST_MISSING = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // latch the input beat
        logic exec;         // push/pop/query: update pointers and write
        logic scan_rd;      // read entry at scan offset
        logic scan_next;    // advance scan offset
        logic set_missing;  // flag value not found
        logic shift_rd;     // read entry after the hole
        logic shift_wr;     // move that entry into the hole, advance
        logic rm_commit;    // drop one entry after removal
        logic rd_front;     // read front slot
        logic rd_back;      // read back slot, capture front data
        logic cap_back;     // capture back data
        logic publish;      // load the result register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_remove;    // latched action is a removal
        logic empty;        // no entries held
        logic match;        // read data equals the operand
        logic scan_last;    // scan offset is the last entry
        logic shift_last;   // no entry left to move after this one
        logic out_free;     // result register can take a beat
    } stat_t;

endpackage

[rtl/bdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bdq_ctrl.sv]
// Sequencer for the bounded deque: steps each action through execute,
// scan, compaction, front/back readout and result hand-off. Uses bdq_pkg.

module bdq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bdq_pkg::stat_t stat,
    output bdq_pkg::cmd_t  cmd
);

    import bdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_COMMIT,
        S_RD_FRONT,
        S_RD_BACK,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;

    // Next state and commands
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    in_stall_next = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_remove)
                begin
                    if (stat.empty)
                    begin
                        cmd.set_missing = 1'b1;
                        state_next      = S_RD_FRONT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_RD_FRONT;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    state_next = stat.scan_last ? S_COMMIT : S_SHIFT_RD;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_missing = 1'b1;
                    state_next      = S_RD_FRONT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_last ? S_COMMIT : S_SHIFT_RD;
            end
            S_COMMIT:
            begin
                cmd.rm_commit = 1'b1;
                state_next    = S_RD_FRONT;
            end
            S_RD_FRONT:
            begin
                if (stat.empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_front = 1'b1;
                    state_next   = S_RD_BACK;
                end
            end
            S_RD_BACK:
            begin
                cmd.rd_back = 1'b1;
                state_next  = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.cap_back = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish   = 1'b1;
                    in_stall_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_stall_next = 1'b0;
            end
        endcase
    end

    // Hold state and the registered input stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

[rtl/bdq_datapath.sv]
// Datapath for the bounded deque: circular entry RAM, front pointer,
// count, scan index and result register. Uses bdq_pkg and bdq_ram.

module bdq_datapath #(
    parameter int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bdq_pkg::cmd_t    cmd,
    output bdq_pkg::stat_t   stat,
    input  bdq_pkg::action_t action,
    input  bdq_pkg::word_t   operand_value,
    input  logic             out_stall,
    output logic             out_valid,
    output bdq_pkg::word_t   front_value,
    output bdq_pkg::word_t   back_value,
    output logic [CW-1:0]    entry_count,
    output logic             is_empty,
    output bdq_pkg::status_t status
);

    import bdq_pkg::*;

    // Physical slot of a logical offset from the front, wrapped once
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0] first_reg;
    logic [CW-1:0] count_reg;
    logic          out_valid_reg;
    logic [AW-1:0] idx_reg;
    action_t       act_reg;
    word_t         opnd_reg;
    status_t       sts_reg;
    word_t         front_cap_reg;
    word_t         back_cap_reg;
    word_t         front_value_reg;
    word_t         back_value_reg;
    logic [CW-1:0] entry_count_reg;
    logic          is_empty_reg;
    status_t       status_reg;

    logic [CW-1:0] idx_p1;
    logic [CW-1:0] cnt_m1;
    logic          full;
    logic          empty;
    logic          push_ok;
    logic [CW-1:0] rd_off;
    logic [CW-1:0] wr_off;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] pop_first;
    logic          wr_en;
    word_t         wr_data;
    word_t         rd_data;

    assign idx_p1    = CW'(idx_reg) + CW'(1);
    assign cnt_m1    = count_reg - CW'(1);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pop_first = slot(first_reg, CW'(1));

    // Read offset: scan entry, entry after the hole, front or back
    always_comb
    begin
        rd_off = '0;
        if (cmd.scan_rd)
        begin
            rd_off = CW'(idx_reg);
        end
        else if (cmd.shift_rd)
        begin
            rd_off = idx_p1;
        end
        else if (cmd.rd_front)
        begin
            rd_off = '0;
        end
        else if (cmd.rd_back)
        begin
            rd_off = cnt_m1;
        end
    end

    // Write offset: the hole during compaction, else the push slot
    always_comb
    begin
        if (cmd.shift_wr)
        begin
            wr_off = CW'(idx_reg);
        end
        else if (act_reg == ACT_PUSH_FRONT)
        begin
            wr_off = CW'(CAPACITY - 1);
        end
        else
        begin
            wr_off = count_reg;
        end
    end

    assign rd_addr = slot(first_reg, rd_off);
    assign wr_addr = slot(first_reg, wr_off);
    assign push_ok = cmd.exec && !full
                     && (act_reg == ACT_PUSH_FRONT || act_reg == ACT_PUSH_BACK);
    assign wr_en   = push_ok || cmd.shift_wr;
    assign wr_data = cmd.shift_wr ? rd_data : opnd_reg;

    bdq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Front pointer, count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (act_reg)
                    ACT_PUSH_FRONT:
                    begin
                        if (!full)
                        begin
                            first_reg <= wr_addr;
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    ACT_PUSH_BACK:
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    ACT_POP_FRONT:
                    begin
                        if (!empty)
                        begin
                            first_reg <= pop_first;
                            count_reg <= cnt_m1;
                        end
                    end
                    ACT_POP_BACK:
                    begin
                        if (!empty)
                        begin
                            count_reg <= cnt_m1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // Drop the removed entry; rewind the pointer when emptied
            if (cmd.rm_commit)
            begin
                count_reg <= cnt_m1;
                if (cnt_m1 == '0)
                begin
                    first_reg <= '0;
                end
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latched beat, scan index, captures and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            opnd_reg <= operand_value;
            idx_reg  <= '0;
            sts_reg  <= ST_DONE;
        end
        if (cmd.exec)
        begin
            if (act_reg inside {ACT_PUSH_FRONT, ACT_PUSH_BACK})
            begin
                if (full)
                begin
                    sts_reg <= ST_FULL;
                end
            end
            else if (act_reg inside {ACT_POP_FRONT, ACT_POP_BACK})
            begin
                if (empty)
                begin
                    sts_reg <= ST_EMPTY;
                end
            end
        end
        if (cmd.set_missing)
        begin
            sts_reg <= ST_MISSING;
        end
        if (cmd.scan_next || cmd.shift_wr)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.rd_back)
        begin
            front_cap_reg <= rd_data;
        end
        if (cmd.cap_back)
        begin
            back_cap_reg <= rd_data;
        end
        if (cmd.publish)
        begin
            front_value_reg <= empty ? '0 : front_cap_reg;
            back_value_reg  <= empty ? '0 : back_cap_reg;
            entry_count_reg <= count_reg;
            is_empty_reg    <= empty;
            status_reg      <= sts_reg;
        end
    end

    // Status to the controller
    assign stat.is_remove  = (act_reg == ACT_REMOVE);
    assign stat.empty      = empty;
    assign stat.match      = (rd_data == opnd_reg);
    assign stat.scan_last  = (idx_p1 == count_reg);
    assign stat.shift_last = ((CW+1)'(idx_reg) + (CW+1)'(2)) >= (CW+1)'(count_reg);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;

endmodule

[rtl/bounded_deque_with_remove.sv]
// Top level of the bounded deque with value removal.
// Uses bdq_pkg, bdq_ctrl and bdq_datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in      | into      | in_valid/in_stall  | action, operand_value
//   out     | out of    | out_valid/out_stall| front_value, back_value, entry_count,
//           |           |                    | is_empty, status
//
// One beat in gives one beat out. Push, pop and query step through execute and the
// front/back readout; remove scans the held entries and, when the value is found,
// moves each later entry into the hole, one RAM read per scanned or moved entry.
// An action that leaves the store empty skips the front/back readout.
// Reset is asynchronous; the store needs no clearing and the block is ready at once.
// A stalled result sits in the output register while the next beat is taken and
// worked; only its own hand-off waits.

module bounded_deque_with_remove #(
    parameter int CAPACITY = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bdq_pkg::action_t action,
    input  bdq_pkg::word_t   operand_value,
    output logic             out_valid,
    input  logic             out_stall,
    output bdq_pkg::word_t   front_value,
    output bdq_pkg::word_t   back_value,
    output logic [CW-1:0]    entry_count,
    output logic             is_empty,
    output bdq_pkg::status_t status
);

    import bdq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .operand_value (operand_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .front_value   (front_value),
        .back_value    (back_value),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .status        (status)
    );

`ifndef ASSERT_OFF
    // An accepted beat closes the input until its result is loaded into the output register
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a beat");

    // A result is never loaded over one still waiting
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid || !out_stall))
        else $error("result register overwritten while stalled");

    // Count and empty flag agree and stay in range
    a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((is_empty == (entry_count == '0))
                       && (entry_count <= CW'(CAPACITY))))
        else $error("entry count and empty flag disagree");

    // An empty store reports zero at both ends
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (front_value == '0 && back_value == '0))
        else $error("nonzero front or back on empty result");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for bounded_deque_with_remove: directed and random deque traffic,
// each result beat checked against a behavioral deque kept here.
// Depends on bdq_pkg and the bounded_deque_with_remove RTL.

module tb_top;
    import bdq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int VIEW_SLOTS  = 4096;

    // Codes with no action of their own; the block treats them as a query
    localparam action_t ACT_SPARE_6 = 3'd6;
    localparam action_t ACT_SPARE_7 = 3'd7;

    localparam word_t WORD_MAX = 32'h7fff_ffff;
    localparam word_t WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        word_t         front;
        word_t         back;
        logic [CW-1:0] count;
        logic          empty;
        status_t       st;
    } deque_view_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    action_t       action;
    word_t         operand_value;
    logic          out_valid;
    logic          out_stall;
    word_t         front_value;
    word_t         back_value;
    logic [CW-1:0] entry_count;
    logic          is_empty;
    status_t       status;

    // Behavioral deque: circular store, head slot and fill level
    word_t       deque_store [CAPACITY];
    int unsigned deque_head;
    int unsigned deque_fill;

    // Expected views in accept order: written at accept, read at result
    deque_view_t deque_views_due [VIEW_SLOTS];
    int          views_sent    = 0;
    int          views_checked = 0;

    int send_idle_pct  = 11;
    int recv_stall_pct = 76;
    int hold_left      = 0;
    int mismatch_count = 0;

    bounded_deque_with_remove #(.CAPACITY(CAPACITY)) DUT (.*);

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one action to the behavioral deque and return the view after it
    function automatic deque_view_t apply_action(input action_t a, input word_t v);
        deque_view_t view;
        status_t     st;
        int unsigned i;
        int unsigned k;
        int unsigned hit;
        bit          found;
        st    = ST_DONE;
        found = 1'b0;
        hit   = 0;
        case (a)
            ACT_PUSH_FRONT:
                if (deque_fill == CAPACITY)
                    st = ST_FULL;
                else
                begin
                    deque_head = (deque_head + CAPACITY - 1) % CAPACITY;
                    deque_store[deque_head] = v;
                    deque_fill++;
                end
            ACT_PUSH_BACK:
                if (deque_fill == CAPACITY)
                    st = ST_FULL;
                else
                begin
                    deque_store[(deque_head + deque_fill) % CAPACITY] = v;
                    deque_fill++;
                end
            ACT_POP_FRONT:
                if (deque_fill == 0)
                    st = ST_EMPTY;
                else
                begin
                    deque_head = (deque_head + 1) % CAPACITY;
                    deque_fill--;
                end
            ACT_POP_BACK:
                if (deque_fill == 0)
                    st = ST_EMPTY;
                else
                    deque_fill--;
            ACT_REMOVE:
            begin
                // find the first match from the front, then close the hole
                for (i = 0; i < deque_fill; i++)
                    if (!found && deque_store[(deque_head + i) % CAPACITY] == v)
                    begin
                        found = 1'b1;
                        hit   = i;
                    end
                if (found)
                begin
                    for (k = hit; k + 1 < deque_fill; k++)
                        deque_store[(deque_head + k) % CAPACITY] =
                            deque_store[(deque_head + k + 1) % CAPACITY];
                    deque_fill--;
                    if (deque_fill == 0)
                        deque_head = 0;
                end
                else
                    st = ST_MISSING;
            end
            default: ;
        endcase
        if (deque_fill == 0)
        begin
            view.front = '0;
            view.back  = '0;
            view.empty = 1'b1;
        end
        else
        begin
            view.front = deque_store[deque_head];
            view.back  = deque_store[(deque_head + deque_fill - 1) % CAPACITY];
            view.empty = 1'b0;
        end
        view.count = CW'(deque_fill);
        view.st    = st;
        return view;
    endfunction

    // Small values repeat often so removals find duplicates
    function automatic word_t pick_push_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 8) - 4;
        if (r < 60)
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                default: return '1;
            endcase
        return $urandom;
    endfunction

    // Mostly target a live entry at any position
    function automatic word_t pick_remove_value();
        if (deque_fill > 0 && $urandom_range(0, 99) < 70)
            return deque_store[(deque_head + $urandom_range(0, deque_fill - 1)) % CAPACITY];
        return pick_push_value();
    endfunction

    // Offer one beat after a random idle gap; record its view once accepted
    task automatic send_beat(input action_t a, input word_t v);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid      <= 1'b0;
            action        <= action_t'($urandom);
            operand_value <= $urandom;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= a;
        operand_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deque_views_due[views_sent % VIEW_SLOTS] = apply_action(a, v);
        views_sent++;
    endtask

    // Pops, removal and spare codes on an empty store
    task automatic test_empty_store();
        send_beat(ACT_POP_FRONT, '0);
        send_beat(ACT_POP_BACK, '1);
        send_beat(ACT_REMOVE, '0);
        send_beat(ACT_SPARE_6, $urandom);
        send_beat(ACT_SPARE_7, $urandom);
        send_beat(ACT_QUERY, $urandom);
    endtask

    // Extreme words, duplicate removal, removal of the back entry, absent value
    task automatic test_extreme_values();
        send_beat(ACT_PUSH_BACK, WORD_MAX);
        send_beat(ACT_PUSH_FRONT, WORD_MIN);
        send_beat(ACT_PUSH_BACK, WORD_MAX);
        send_beat(ACT_QUERY, '0);
        send_beat(ACT_REMOVE, WORD_MAX);
        send_beat(ACT_REMOVE, WORD_MAX);
        send_beat(ACT_REMOVE, 32'sd1);
        send_beat(ACT_POP_BACK, '0);
        send_beat(ACT_POP_FRONT, '0);
    endtask

    // Hold the result side while pushes keep coming: fill, refuse, back up input
    task automatic test_backpressure();
        int n;
        hold_left = HOLD_CYCLES;
        for (n = 0; n < CAPACITY + 4; n++)
            send_beat($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                      pick_push_value());
    endtask

    // Random traffic; the action mix drifts between filling and draining
    task automatic test_mixed_traffic(input int n_beats, input int send_pct,
                                      input int recv_pct);
        int      i;
        int      r;
        int      bias;
        int      push_w [3] = '{15, 40, 65};
        int      pop_w  [3] = '{50, 30, 15};
        action_t a;
        word_t   v;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        bias           = 1;
        for (i = 0; i < n_beats; i++)
        begin
            if (i % 40 == 0)
                bias = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            v = pick_push_value();
            if (r < push_w[bias])
                a = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else if (r < push_w[bias] + pop_w[bias])
                a = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
            else if (r < 92)
            begin
                a = ACT_REMOVE;
                v = pick_remove_value();
            end
            else
                case ($urandom_range(0, 3))
                    0: a = ACT_SPARE_6;
                    1: a = ACT_SPARE_7;
                    default: a = ACT_QUERY;
                endcase
            send_beat(a, v);
        end
    endtask

    // Reset, run the tests in turn, drain and report
    initial
    begin : main_sequence
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_QUERY;
        operand_value = '0;
        deque_head    = 0;
        deque_fill    = 0;
        foreach (deque_store[j])
            deque_store[j] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_extreme_values();
        test_backpressure();
        test_mixed_traffic(620, 11, 76);
        test_mixed_traffic(620, 76, 11);
        test_mixed_traffic(620, 0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (views_checked != views_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stall, or a long hold-off when one is requested
    initial
    begin : result_sink
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result beat with the oldest outstanding view
    always @(posedge clk)
    begin : result_check
        deque_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (views_checked == views_sent)
            begin
                $error("result beat with no action outstanding");
                mismatch_count++;
            end
            else
            begin
                want = deque_views_due[views_checked % VIEW_SLOTS];
                views_checked++;
                check_field("front_value", want.front, front_value);
                check_field("back_value", want.back, back_value);
                check_field("entry_count", want.count, entry_count);
                check_field("is_empty", want.empty, is_empty);
                check_field("status", want.st, status);
            end
        end
    end

    // End the run when no beat moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
